@@ design/etf_pkg.sv @@
`default_nettype none
package etf_pkg;

  localparam int WORD_W    = 64;
  localparam int COL_W     = 12;
  localparam int ITER_W    = 10;
  localparam int VAR_W     = 2;
  localparam int STEP_W    = 63;
  localparam int CFG_IDX_W = 3;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [COL_W-1:0]     coord_t;
  typedef logic [ITER_W-1:0]    iter_t;
  typedef logic [VAR_W-1:0]     variant_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam word_t SMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t SMIN = {1'b1, {(WORD_W-1){1'b0}}};

  // register indexes on the configuration channel
  localparam cfg_idx_t REG_MAX_ITER  = 3'd0;
  localparam cfg_idx_t REG_VARIANT   = 3'd1;
  localparam cfg_idx_t REG_REAL_MIN  = 3'd2;
  localparam cfg_idx_t REG_REAL_STEP = 3'd3;
  localparam cfg_idx_t REG_IMAG_MIN  = 3'd4;
  localparam cfg_idx_t REG_IMAG_STEP = 3'd5;

  // fractal variants; any other code steps as Mandelbrot
  localparam variant_t VAR_MANDELBROT = 2'd0;
  localparam variant_t VAR_BURNING    = 2'd1;
  localparam variant_t VAR_TRICORN    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_PREP,
    ST_SQ_X,
    ST_SQ_Y,
    ST_CROSS,
    ST_UPDATE,
    ST_MAG_X,
    ST_MAG_Y,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic int_mode;
  } mul_req_t;

endpackage
`default_nettype wire

@@ design/etf_ifs.sv @@
`default_nettype none
interface etf_in_if;
  logic           valid;
  logic           ready;
  etf_pkg::coord_t pixel_column;
  etf_pkg::coord_t pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface etf_out_if;
  logic            valid;
  logic            ready;
  etf_pkg::coord_t out_column;
  etf_pkg::coord_t out_row;
  etf_pkg::iter_t  iteration_count;
  logic            escaped;

  modport source (output valid, output out_column, output out_row,
                  output iteration_count, output escaped, input ready);
  modport sink   (input valid, input out_column, input out_row,
                  input iteration_count, input escaped, output ready);
endinterface

interface etf_cfg_if;
  logic              valid;
  logic              ready;
  etf_pkg::cfg_idx_t index;
  etf_pkg::word_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/etf_fxmul.sv @@
`default_nettype none
// Signed fixed-point multiplier built on one 32x32 unsigned multiplier.
// Four partial products of the operand magnitudes are summed into a
// 128-bit accumulator, the sign is applied, and the result is floored and
// saturated. Integer mode returns the plain product saturated to SMAX.
module etf_fxmul #(
  parameter int FRAC_BITS = 60
) (
  input  wire                clk,
  input  wire                rst_n,
  input  etf_pkg::mul_req_t  req,
  input  etf_pkg::word_t     op_a,
  input  etf_pkg::word_t     op_b,
  output logic               done,
  output etf_pkg::word_t     res
);

  localparam int W      = etf_pkg::WORD_W;
  localparam int HALF   = W / 2;
  localparam int ACC_W  = 2 * W;
  localparam int HI_LSB = FRAC_BITS + W - 1;

  localparam logic [2:0] PH_PP_LAST  = 3'd3;
  localparam logic [2:0] PH_ACC_LAST = 3'd4;
  localparam logic [2:0] PH_NEG      = 3'd5;
  localparam logic [2:0] PH_OUT      = 3'd6;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [2:0]         phase_r, phase_nxt;
  etf_pkg::word_t     a_r, b_r, res_r;
  logic               neg_r, int_r;
  logic [W-1:0]       pp_r;
  logic [ACC_W-1:0]   acc_r;

  logic               load;
  logic [HALF-1:0]    a_half, b_half;
  logic [W-1:0]       prod;
  logic [ACC_W-1:0]   pp_ext, acc_add, acc_neg;
  logic [ACC_W-HI_LSB-1:0] hi_bits;
  logic               fx_ovf, int_ovf;
  etf_pkg::word_t     fx_val, int_val;

  assign load = req.start && !busy_r;

  always_comb begin
    // phase bit 1 picks the upper half of a, bit 0 the upper half of b
    a_half = phase_r[1] ? a_r[W-1:HALF] : a_r[HALF-1:0];
    b_half = phase_r[0] ? b_r[W-1:HALF] : b_r[HALF-1:0];
    prod   = a_half * b_half;

    // pp_r holds the partial product issued in the previous phase
    case (phase_r) inside
      3'd1:        pp_ext = ACC_W'(pp_r);
      3'd2, 3'd3:  pp_ext = ACC_W'(pp_r) << HALF;
      3'd4:        pp_ext = ACC_W'(pp_r) << W;
      default:     pp_ext = '0;
    endcase
    acc_add = acc_r + pp_ext;
    acc_neg = neg_r ? (~acc_r + ACC_W'(1)) : acc_r;

    hi_bits = acc_r[ACC_W-1:HI_LSB];
    fx_ovf  = !((&hi_bits) || !(|hi_bits));
    fx_val  = fx_ovf ? (acc_r[ACC_W-1] ? etf_pkg::SMIN : etf_pkg::SMAX)
                     : acc_r[HI_LSB -: W];
    int_ovf = |acc_r[ACC_W-1:W-1];
    int_val = int_ovf ? etf_pkg::SMAX : acc_r[W-1:0];
  end

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    if (load) begin
      busy_nxt  = 1'b1;
      phase_nxt = '0;
    end else if (busy_r) begin
      phase_nxt = phase_r + 3'd1;
      if (phase_r == PH_OUT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= op_a[W-1] ? (~op_a + W'(1)) : op_a;
      b_r   <= op_b[W-1] ? (~op_b + W'(1)) : op_b;
      neg_r <= !req.int_mode && (op_a[W-1] ^ op_b[W-1]);
      int_r <= req.int_mode;
      acc_r <= '0;
    end else if (busy_r) begin
      if (phase_r <= PH_PP_LAST) begin
        pp_r <= prod;
      end
      if (phase_r != 3'd0 && phase_r <= PH_ACC_LAST) begin
        acc_r <= acc_add;
      end
      if (phase_r == PH_NEG) begin
        acc_r <= acc_neg;
      end
      if (phase_r == PH_OUT) begin
        res_r <= int_r ? int_val : fx_val;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

@@ design/escape_time_fractal_pixel_core.sv @@
`default_nettype none
// Channel   Dir  Payload                                        Handshake
// in_ch     in   pixel_column, pixel_row                        valid/ready
// out_ch    out  out_column, out_row, iteration_count, escaped  valid/ready
// cfg_ch    in   index, data                                    valid/ready
//
// One pixel at a time. Every product goes through the shared 32x32
// multiplier in etf_fxmul, four partial products each; an item needs
// five products per iteration performed, plus two for the coordinate
// mapping.
// Synchronous active-low reset restores the register defaults; the result
// register lets the next pixel start while a finished one waits on out_ch.
module escape_time_fractal_pixel_core #(
  parameter int FRAC_BITS  = 60,
  parameter int COORD_BITS = 12
) (
  input  wire             clk,
  input  wire             rst_n,
  etf_in_if.sink          in_ch,
  etf_out_if.source       out_ch,
  etf_cfg_if.sink         cfg_ch
);

  localparam int W  = etf_pkg::WORD_W;
  localparam int CW = etf_pkg::COL_W;
  localparam int IW = etf_pkg::ITER_W;
  localparam etf_pkg::word_t FOUR = W'(4) << FRAC_BITS;
  localparam etf_pkg::coord_t COORD_MASK =
    (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);

  function automatic etf_pkg::word_t sat_add(etf_pkg::word_t a, etf_pkg::word_t b);
    etf_pkg::word_t r;
    r = a + b;
    if (((a ^ r) & (b ^ r)) >> (W - 1) != '0)
      return a[W-1] ? etf_pkg::SMIN : etf_pkg::SMAX;
    return r;
  endfunction

  function automatic etf_pkg::word_t sat_sub(etf_pkg::word_t a, etf_pkg::word_t b);
    etf_pkg::word_t r;
    r = a - b;
    if (((a ^ b) & (a ^ r)) >> (W - 1) != '0)
      return a[W-1] ? etf_pkg::SMIN : etf_pkg::SMAX;
    return r;
  endfunction

  function automatic etf_pkg::word_t sat_neg(etf_pkg::word_t a);
    return (a == etf_pkg::SMIN) ? etf_pkg::SMAX : (~a + W'(1));
  endfunction

  function automatic etf_pkg::word_t sat_abs(etf_pkg::word_t a);
    return a[W-1] ? sat_neg(a) : a;
  endfunction

  // configuration
  etf_pkg::iter_t    max_iter_r;
  etf_pkg::variant_t variant_r;
  etf_pkg::word_t    real_min_r, imag_min_r;
  etf_pkg::step_t    real_step_r, imag_step_r;

  // sequencer and datapath
  etf_pkg::state_t   state_r, state_nxt;
  logic              wait_r, wait_nxt;
  etf_pkg::coord_t   col_r, row_r;
  etf_pkg::word_t    cx_r, cy_r, x_r, y_r, sx_r, sy_r;
  etf_pkg::word_t    xx_r, yy_r, d_r, t_r;
  etf_pkg::iter_t    iter_r;
  etf_pkg::iter_t    res_cnt_r;
  logic              res_esc_r;

  logic              out_valid_r;
  etf_pkg::coord_t   out_col_r, out_row_r;
  etf_pkg::iter_t    out_cnt_r;
  logic              out_esc_r;

  etf_pkg::mul_req_t mul_req;
  etf_pkg::word_t    mul_a, mul_b, mul_res;
  logic              mul_done;
  logic              mul_state;
  logic              load_out;
  logic              in_accept;
  etf_pkg::word_t    sx_nxt, sy_nxt, mag;
  logic              esc, last_iter;

  etf_fxmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .op_a (mul_a),
    .op_b (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= IW'(100);
      variant_r   <= etf_pkg::VAR_MANDELBROT;
      real_min_r  <= '0;
      real_step_r <= '0;
      imag_min_r  <= '0;
      imag_step_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        etf_pkg::REG_MAX_ITER:  max_iter_r  <= cfg_ch.data[IW-1:0];
        etf_pkg::REG_VARIANT:   variant_r   <= cfg_ch.data[etf_pkg::VAR_W-1:0];
        etf_pkg::REG_REAL_MIN:  real_min_r  <= cfg_ch.data;
        etf_pkg::REG_REAL_STEP: real_step_r <= cfg_ch.data[etf_pkg::STEP_W-1:0];
        etf_pkg::REG_IMAG_MIN:  imag_min_r  <= cfg_ch.data;
        etf_pkg::REG_IMAG_STEP: imag_step_r <= cfg_ch.data[etf_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // step operands for the selected variant
  always_comb begin
    sx_nxt = x_r;
    sy_nxt = y_r;
    case (variant_r)
      etf_pkg::VAR_BURNING: begin
        sx_nxt = sat_abs(x_r);
        sy_nxt = sat_abs(y_r);
      end
      etf_pkg::VAR_TRICORN: sy_nxt = sat_neg(y_r);
      default: ;
    endcase
    mag       = sat_add(xx_r, yy_r);
    esc       = mag > FOUR;
    last_iter = (iter_r + IW'(1)) == max_iter_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      etf_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = etf_pkg::ST_MAP_X;
      etf_pkg::ST_MAP_X:  if (mul_done) state_nxt = etf_pkg::ST_MAP_Y;
      etf_pkg::ST_MAP_Y: begin
        if (mul_done) begin
          state_nxt = (max_iter_r == '0) ? etf_pkg::ST_DONE : etf_pkg::ST_PREP;
        end
      end
      etf_pkg::ST_PREP:   state_nxt = etf_pkg::ST_SQ_X;
      etf_pkg::ST_SQ_X:   if (mul_done) state_nxt = etf_pkg::ST_SQ_Y;
      etf_pkg::ST_SQ_Y:   if (mul_done) state_nxt = etf_pkg::ST_CROSS;
      etf_pkg::ST_CROSS:  if (mul_done) state_nxt = etf_pkg::ST_UPDATE;
      etf_pkg::ST_UPDATE: state_nxt = etf_pkg::ST_MAG_X;
      etf_pkg::ST_MAG_X:  if (mul_done) state_nxt = etf_pkg::ST_MAG_Y;
      etf_pkg::ST_MAG_Y:  if (mul_done) state_nxt = etf_pkg::ST_TEST;
      etf_pkg::ST_TEST: begin
        state_nxt = (esc || last_iter) ? etf_pkg::ST_DONE : etf_pkg::ST_PREP;
      end
      etf_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = etf_pkg::ST_IDLE;
      end
      default: state_nxt = etf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready      = 1'b0;
    mul_state        = 1'b0;
    mul_req.int_mode = 1'b0;
    mul_a            = x_r;
    mul_b            = x_r;
    load_out         = 1'b0;
    unique case (state_r)
      etf_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      etf_pkg::ST_MAP_X: begin
        mul_state        = 1'b1;
        mul_req.int_mode = 1'b1;
        mul_a            = W'(col_r);
        mul_b            = W'(real_step_r);
      end
      etf_pkg::ST_MAP_Y: begin
        mul_state        = 1'b1;
        mul_req.int_mode = 1'b1;
        mul_a            = W'(row_r);
        mul_b            = W'(imag_step_r);
      end
      etf_pkg::ST_SQ_X: begin
        mul_state = 1'b1;
        mul_a     = sx_r;
        mul_b     = sx_r;
      end
      etf_pkg::ST_SQ_Y: begin
        mul_state = 1'b1;
        mul_a     = sy_r;
        mul_b     = sy_r;
      end
      etf_pkg::ST_CROSS: begin
        mul_state = 1'b1;
        mul_a     = sx_r;
        mul_b     = sy_r;
      end
      etf_pkg::ST_MAG_X: begin
        mul_state = 1'b1;
        mul_a     = x_r;
        mul_b     = x_r;
      end
      etf_pkg::ST_MAG_Y: begin
        mul_state = 1'b1;
        mul_a     = y_r;
        mul_b     = y_r;
      end
      etf_pkg::ST_DONE: load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
    mul_req.start = mul_state && !wait_r;
  end

  assign in_accept = in_ch.valid && in_ch.ready;

  // hold off a second start until the product is back
  always_comb begin
    wait_nxt = wait_r;
    if (mul_req.start) begin
      wait_nxt = 1'b1;
    end else if (mul_done) begin
      wait_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= etf_pkg::ST_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      col_r <= in_ch.pixel_column & COORD_MASK;
      row_r <= in_ch.pixel_row & COORD_MASK;
    end
    case (state_r)
      etf_pkg::ST_MAP_X: if (mul_done) cx_r <= sat_add(real_min_r, mul_res);
      etf_pkg::ST_MAP_Y: begin
        if (mul_done) begin
          cy_r      <= sat_add(imag_min_r, mul_res);
          x_r       <= '0;
          y_r       <= '0;
          iter_r    <= '0;
          res_cnt_r <= '0;
          res_esc_r <= 1'b0;
        end
      end
      etf_pkg::ST_PREP: begin
        sx_r <= sx_nxt;
        sy_r <= sy_nxt;
      end
      etf_pkg::ST_SQ_X:  if (mul_done) xx_r <= mul_res;
      etf_pkg::ST_SQ_Y:  if (mul_done) d_r <= sat_sub(xx_r, mul_res);
      etf_pkg::ST_CROSS: if (mul_done) t_r <= sat_add(mul_res, mul_res);
      etf_pkg::ST_UPDATE: begin
        x_r <= sat_add(d_r, cx_r);
        y_r <= sat_add(t_r, cy_r);
      end
      etf_pkg::ST_MAG_X: if (mul_done) xx_r <= mul_res;
      etf_pkg::ST_MAG_Y: if (mul_done) yy_r <= mul_res;
      etf_pkg::ST_TEST: begin
        res_esc_r <= esc;
        res_cnt_r <= esc ? iter_r : max_iter_r;
        iter_r    <= iter_r + IW'(1);
      end
      default: ;
    endcase
    if (load_out) begin
      out_col_r <= col_r;
      out_row_r <= row_r;
      out_cnt_r <= res_cnt_r;
      out_esc_r <= res_esc_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_column      = out_col_r;
  assign out_ch.out_row         = out_row_r;
  assign out_ch.iteration_count = out_cnt_r;
  assign out_ch.escaped         = out_esc_r;

  a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> wait_r)
    else $error("multiplier returned a product that was never requested");

  a_iter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == etf_pkg::ST_TEST) |-> (iter_r < max_iter_r))
    else $error("iteration counter ran past the limit");

  a_escaped_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.escaped) |-> (out_ch.iteration_count < max_iter_r))
    else $error("escaped pixel reports a count at or above the limit");

  a_bounded_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.escaped) |-> (out_ch.iteration_count == max_iter_r))
    else $error("bounded pixel does not report the full limit");

endmodule
`default_nettype wire
